// ===== hdl/assert_macros.svh =====
// Assertion macros for the sliding-window class vote RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SWCV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define SWCV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

// ===== hdl/swcv_pkg.sv =====
// Package for the sliding-window class vote: sizes, register codes, helpers.
// Used by swcv_ring, swcv_cnt_mem and sliding_window_class_vote_core.
`timescale 1ns / 1ps

package swcv_pkg;

  localparam int WINDOW      = 32;
  localparam int NUM_CLASSES = 16;

  // Fixed field widths.
  localparam int LABEL_W    = 4;
  localparam int WIN_W      = 4;
  localparam int MV_W       = 6;
  localparam int MC_W       = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Derived sizes.
  localparam int RING_AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W  = $clog2(WINDOW + 1);
  localparam int CNT_W   = FILL_W;
  localparam int MRG_W   = CNT_W + 1;
  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CLS_XW  = (CLS_W > LABEL_W) ? CLS_W : LABEL_W;
  localparam int CMP_W   = (MRG_W > MV_W) ? MRG_W : MV_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOTES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_TARGET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_SOURCE = 2'd2;

  localparam logic [MV_W-1:0] MIN_VOTES_RST    = 6'd16;
  localparam logic [MC_W-1:0] MERGE_TARGET_RST = 4'd1;
  localparam logic [MC_W-1:0] MERGE_SOURCE_RST = 4'd2;

  typedef logic [CLS_W-1:0] cls_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic push;
    logic clr;
  } ring_ctl_t;

  typedef struct packed {
    cls_t rd_addr;
    logic wr_en;
    cls_t wr_addr;
    cnt_t wr_data;
    logic clr;
  } cnt_req_t;

  // True when a 4-bit class code names a class that exists.
  function automatic logic cls_ok(input logic [LABEL_W-1:0] v);
    logic [CLS_XW:0] w;
    w = (CLS_XW + 1)'(v);
    return w < (CLS_XW + 1)'(NUM_CLASSES);
  endfunction

  // Resize a 4-bit class code to a class index.
  function automatic cls_t to_cls(input logic [LABEL_W-1:0] v);
    logic [CLS_XW-1:0] w;
    w = CLS_XW'(v);
    return w[CLS_W-1:0];
  endfunction

  // Keep the low bits of a class index for the winner field.
  function automatic logic [WIN_W-1:0] to_win(input cls_t c);
    logic [CLS_XW-1:0] w;
    w = CLS_XW'(c);
    return w[WIN_W-1:0];
  endfunction

endpackage

// ===== hdl/sliding_window_class_vote_core.sv =====
// Sliding-window class vote: top level with sequencer and shared compare unit.
// Depends on swcv_pkg, swcv_ring, swcv_cnt_mem and assert_macros.svh.
//
// Input channel (in_valid / in_stall, fields in_op, in_label): a transaction
// is taken when in_valid is high and in_stall low. in_op 0 votes for
// in_label, in_op 1 clears the window and every class count.
// Result channel (out_valid / out_stall, field out_winner): exactly one
// transaction per input transaction, in order, held in an output register
// until taken.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): cfg_ready is
// always high; index 0 min_votes, 1 merge target class, 2 merge source
// class, other indexes are ignored. Write only while the block is idle.
// Steps follow the single read port of the count memory: for a vote, count
// update (a decrement first once the ring is full), two merge reads, then one
// read and one compare per class from class 1 upward; a clear goes straight to
// the result state. in_stall stays high until the result sits in the output
// register, so no new transaction is taken before the last one is through.
// A stalled receiver holds the sequencer in its result state, so no
// transaction is lost. rst_n clears counts, ring fill and head, loads
// the register defaults and empties the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sliding_window_class_vote_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [swcv_pkg::LABEL_W-1:0]        in_label,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [swcv_pkg::WIN_W-1:0]          out_winner,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swcv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swcv_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import swcv_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC_RD = 4'd1;
  localparam logic [3:0] S_DEC_WR = 4'd2;
  localparam logic [3:0] S_INC_RD = 4'd3;
  localparam logic [3:0] S_INC_WR = 4'd4;
  localparam logic [3:0] S_MT_RD  = 4'd5;
  localparam logic [3:0] S_MS_RD  = 4'd6;
  localparam logic [3:0] S_MERGE  = 4'd7;
  localparam logic [3:0] S_SCAN   = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0]          state_r;
  logic [3:0]          state_nxt;

  // Configuration registers.
  logic [MV_W-1:0]     min_votes_r;
  logic [MC_W-1:0]     mrg_tgt_r;
  logic [MC_W-1:0]     mrg_src_r;

  // Datapath registers.
  cls_t                label_r;
  cnt_t                tgt_cnt_r;
  logic [MRG_W-1:0]    merged_r;
  logic                mrg_on_r;
  cls_t                pend_idx_r;
  logic [MRG_W-1:0]    best_r;
  cls_t                best_idx_r;
  logic [WIN_W-1:0]    res_r;
  logic                out_valid_r;
  logic [WIN_W-1:0]    out_winner_r;

  ring_ctl_t           ring_ctl;
  cls_t                old_label;
  logic                ring_full;
  cnt_req_t            cnt_req;
  cnt_t                cnt_rd;

  logic                in_acc;
  logic                clr_acc;
  logic                vote_acc;
  logic                out_acc;
  logic                out_load;
  logic [MRG_W-1:0]    scan_val;
  logic                scan_take;
  logic                scan_last;
  logic                mrg_ok;

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign clr_acc    = in_acc && in_op;
  assign vote_acc   = in_acc && !in_op;
  assign out_valid  = out_valid_r;
  assign out_winner = out_winner_r;
  assign out_acc    = out_valid_r && !out_stall;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign cfg_ready  = 1'b1;

  swcv_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ring_ctl),
    .wr_label  (label_r),
    .old_label (old_label),
    .full      (ring_full)
  );

  swcv_cnt_mem u_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (cnt_req),
    .rd_data (cnt_rd)
  );

  // Configuration writes; unknown indexes fall through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_votes_r <= MIN_VOTES_RST;
      mrg_tgt_r   <= MERGE_TARGET_RST;
      mrg_src_r   <= MERGE_SOURCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_VOTES:    min_votes_r <= cfg_data[MV_W-1:0];
        CFG_MERGE_TARGET: mrg_tgt_r   <= cfg_data[MC_W-1:0];
        CFG_MERGE_SOURCE: mrg_src_r   <= cfg_data[MC_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared compare unit: one class count per cycle against the running best.
  // The merged count replaces the target class count when the merge applies.
  assign scan_val  = (mrg_on_r && (pend_idx_r == to_cls(mrg_tgt_r))) ?
                     merged_r : MRG_W'(cnt_rd);
  assign scan_take = (pend_idx_r == CLS_W'(1)) || (scan_val > best_r);
  assign scan_last = (pend_idx_r == CLS_W'(NUM_CLASSES - 1));
  assign mrg_ok    = cls_ok(mrg_tgt_r) && cls_ok(mrg_src_r) && (tgt_cnt_r != '0);

  // Sequencer and memory requests.
  always_comb begin
    state_nxt       = state_r;
    ring_ctl        = '0;
    cnt_req         = '0;
    cnt_req.wr_addr = label_r;
    cnt_req.wr_data = cnt_rd + 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op) begin
            ring_ctl.clr = 1'b1;
            cnt_req.clr  = 1'b1;
            state_nxt    = S_OUT;
          end else begin
            state_nxt = ring_full ? S_DEC_RD : S_INC_RD;
          end
        end
      end
      S_DEC_RD: begin
        cnt_req.rd_addr = old_label;
        state_nxt       = S_DEC_WR;
      end
      S_DEC_WR: begin
        // Drop the oldest label from its count.
        cnt_req.wr_en   = (cnt_rd != '0);
        cnt_req.wr_addr = old_label;
        cnt_req.wr_data = cnt_rd - 1'b1;
        state_nxt       = S_INC_RD;
      end
      S_INC_RD: begin
        cnt_req.rd_addr = label_r;
        ring_ctl.push   = 1'b1;
        state_nxt       = S_INC_WR;
      end
      S_INC_WR: begin
        cnt_req.wr_en = 1'b1;
        state_nxt     = S_MT_RD;
      end
      S_MT_RD: begin
        cnt_req.rd_addr = to_cls(mrg_tgt_r);
        state_nxt       = S_MS_RD;
      end
      S_MS_RD: begin
        cnt_req.rd_addr = to_cls(mrg_src_r);
        state_nxt       = S_MERGE;
      end
      S_MERGE: begin
        cnt_req.rd_addr = CLS_W'(1);
        state_nxt       = S_SCAN;
      end
      S_SCAN: begin
        cnt_req.rd_addr = pend_idx_r + 1'b1;
        if (scan_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers, advanced by state.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        label_r <= cls_ok(in_label) ? to_cls(in_label) : '0;
        res_r   <= '0;
      end
      S_MS_RD: begin
        tgt_cnt_r <= cnt_rd;
      end
      S_MERGE: begin
        merged_r   <= MRG_W'(tgt_cnt_r) + MRG_W'(cnt_rd);
        mrg_on_r   <= mrg_ok;
        pend_idx_r <= CLS_W'(1);
      end
      S_SCAN: begin
        if (scan_take) begin
          best_r     <= scan_val;
          best_idx_r <= pend_idx_r;
        end
        pend_idx_r <= pend_idx_r + 1'b1;
      end
      S_FIN: begin
        res_r <= (CMP_W'(best_r) >= CMP_W'(min_votes_r)) ? to_win(best_idx_r) : '0;
      end
      default: ;
    endcase
  end

  // Output register: hold until taken, refill only from the final state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_winner_r <= res_r;
    end
  end

  // A clear goes straight to the result stage with no winner.
  `SWCV_ASSERT(a_clear_result, clr_acc |=> (state_r == S_OUT && res_r == '0), "clear not zero")

  // A vote never skips the count update.
  `SWCV_ASSERT(a_vote_busy, vote_acc |=> (state_r == S_DEC_RD || state_r == S_INC_RD), "vote idle")

  // The output register is only filled from the result stage.
  `SWCV_ASSERT(a_out_source, $rose(out_valid_r) |-> ($past(state_r) == S_OUT), "stray load")

  // Reset empties the output register.
  `SWCV_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

// ===== hdl/swcv_ring.sv =====
// Label ring of the last WINDOW votes with head pointer and fill count.
// Depends on swcv_pkg. The oldest label is read from the head slot, registered.
`timescale 1ns / 1ps

module swcv_ring (
  input  logic             clk,
  input  logic             rst_n,
  input  swcv_pkg::ring_ctl_t ctl,
  input  swcv_pkg::cls_t   wr_label,
  output swcv_pkg::cls_t   old_label,
  output logic             full
);
  import swcv_pkg::*;

  cls_t                 mem [WINDOW];
  cls_t                 rd_q;
  logic [RING_AW-1:0]   head_r;
  logic [RING_AW-1:0]   head_nxt;
  logic [FILL_W-1:0]    fill_r;
  logic [FILL_W-1:0]    fill_nxt;

  assign full      = (fill_r == FILL_W'(WINDOW));
  assign old_label = rd_q;

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (ctl.clr) begin
      head_nxt = '0;
      fill_nxt = '0;
    end else if (ctl.push) begin
      head_nxt = (head_r == RING_AW'(WINDOW - 1)) ? '0 : head_r + 1'b1;
      if (!full) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Slot under the head holds the oldest label once the ring is full.
  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clr) begin
      mem[head_r] <= wr_label;
    end
    rd_q <= mem[head_r];
  end

endmodule

// ===== hdl/swcv_cnt_mem.sv =====
// Per-class vote counts: one-read one-write memory with registered read.
// Depends on swcv_pkg. Valid bits make an unwritten or cleared entry read as 0.
`timescale 1ns / 1ps

module swcv_cnt_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  swcv_pkg::cnt_req_t req,
  output swcv_pkg::cnt_t     rd_data
);
  import swcv_pkg::*;

  cnt_t                    mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0]  vld_r;
  cnt_t                    rd_q;
  logic                    rd_vld_q;

  assign rd_data = rd_vld_q ? rd_q : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clr) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en && !req.clr) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_q     <= mem[req.rd_addr];
    rd_vld_q <= vld_r[req.rd_addr] && !req.clr;
  end

endmodule
